[sv/vcfe_pkg.sv]
// ----------------------------------------------------------------------------
// Velocity command frame encoder package
// Shared types, frame constants and register indexes for the encoder.
// ----------------------------------------------------------------------------
package vcfe_pkg;

    // Frame layout
    localparam int FRAME_LEN    = 24;
    localparam int PREAMBLE_LEN = 3;
    localparam int PAYLOAD_END  = 21;
    localparam int POS_W        = 5;

    // Byte values
    localparam logic [7:0] K_BYTE  = 8'h6B;
    localparam logic [7:0] NL_BYTE = 8'h0A;
    localparam logic [7:0] LC_R    = 8'h72;
    localparam logic [7:0] UC_R    = 8'h52;
    localparam logic [7:0] LC_W    = 8'h77;
    localparam logic [7:0] UC_W    = 8'h57;
    localparam logic [7:0] HI_CAP  = 8'd127;
    localparam logic [7:0] LO_CAP  = 8'd255;

    // Configuration
    localparam int         LIMIT_W     = 15;
    localparam logic [14:0] LIMIT_RESET = 15'd1500;
    localparam int         CFG_IDX_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIMIT_X   = 2'd0,
        CFG_LIMIT_Y   = 2'd1,
        CFG_LIMIT_ROT = 2'd2
    } t_cfg_idx;

    // Queue between front and back
    localparam int Q_DEPTH_DEFAULT = 2;

    // Six encoded bytes: x hi, x lo, y hi, y lo, rot hi, rot lo (element 0 first)
    typedef logic [5:0][7:0] t_enc;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[sv/vcfe_front.sv]
// ----------------------------------------------------------------------------
// Velocity command frame encoder: front end
// Holds the limit registers, accepts commands and turns them into six bytes.
// ----------------------------------------------------------------------------
module vcfe_front
    import vcfe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [LIMIT_W-1:0]    i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic signed [15:0]    i_speed_x,
    input  logic signed [15:0]    i_speed_y,
    input  logic signed [15:0]    i_speed_rot,
    input  t_q_status             i_q_status,
    output logic                  o_push,
    output t_enc                  o_enc
);

    logic [LIMIT_W-1:0]  r_limit_x;
    logic [LIMIT_W-1:0]  r_limit_y;
    logic [LIMIT_W-1:0]  r_limit_rot;
    logic                r_valid;
    logic signed [15:0]  r_sx;
    logic signed [15:0]  r_sy;
    logic signed [15:0]  r_sr;

    logic                ready;
    logic                accept;
    logic signed [15:0]  cx;
    logic signed [15:0]  cy;
    logic signed [15:0]  cr;
    logic signed [15:0]  qr;

    function automatic logic signed [15:0] clamp_mag(input logic signed [15:0] v,
                                                     input logic [LIMIT_W-1:0] lim);
        logic signed [15:0] l;
        l = signed'({1'b0, lim});
        if (v > l) begin
            return l;
        end else if (v < -l) begin
            return -l;
        end else begin
            return v;
        end
    endfunction

    function automatic logic is_reserved(input logic [7:0] b);
        return (b == NL_BYTE) || (b == LC_R) || (b == UC_R) || (b == LC_W) || (b == UC_W);
    endfunction

    // Negative values use 0xFFFF - |v|, which is v - 1 modulo 2^16.
    function automatic logic [15:0] encode(input logic signed [15:0] v);
        logic [15:0] code;
        logic [7:0]  h;
        logic [7:0]  l;
        code = v[15] ? 16'(v - 16'sd1) : 16'(v);
        h    = code[15:8];
        l    = code[7:0];
        if (h < HI_CAP) begin
            h = h + 8'd1;
        end
        if (l < LO_CAP) begin
            l = l + 8'd1;
        end
        if (is_reserved(h)) begin
            h = h - 8'd1;
        end
        if (is_reserved(l)) begin
            l = l - 8'd1;
        end
        return {h, l};
    endfunction

    assign ready      = !r_valid || !i_q_status.full;
    assign accept     = i_in_valid && ready;
    assign o_in_stall = !ready;
    assign o_push     = r_valid && !i_q_status.full;

    always_comb begin
        cx = clamp_mag(r_sx, r_limit_x);
        cy = clamp_mag(r_sy, r_limit_y);
        cr = clamp_mag(r_sr, r_limit_rot);
        // Division by four, rounding toward zero.
        qr = cr[15] ? ((cr + 16'sd3) >>> 2) : (cr >>> 2);
        {o_enc[0], o_enc[1]} = encode(cx);
        {o_enc[2], o_enc[3]} = encode(cy);
        {o_enc[4], o_enc[5]} = encode(qr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_x   <= LIMIT_RESET;
            r_limit_y   <= LIMIT_RESET;
            r_limit_rot <= LIMIT_RESET;
            r_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_LIMIT_X:   r_limit_x   <= i_cfg_data;
                    CFG_LIMIT_Y:   r_limit_y   <= i_cfg_data;
                    CFG_LIMIT_ROT: r_limit_rot <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_valid <= 1'b1;
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sx <= i_speed_x;
            r_sy <= i_speed_y;
            r_sr <= i_speed_rot;
        end
    end

endmodule

[sv/vcfe_queue.sv]
// ----------------------------------------------------------------------------
// Velocity command frame encoder: command queue
// Small first-in first-out store of encoded commands between front and back.
// ----------------------------------------------------------------------------
module vcfe_queue
    import vcfe_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_enc      i_data,
    input  logic      i_pop,
    output t_enc      o_data,
    output t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_enc             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_data         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[sv/vcfe_back.sv]
// ----------------------------------------------------------------------------
// Velocity command frame encoder: back end
// Serialises one queued command into its 24-byte frame through an output register.
// ----------------------------------------------------------------------------
module vcfe_back
    import vcfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_status  i_q_status,
    input  t_enc       i_q_data,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_frame_byte,
    output logic       o_frame_last
);

    logic             r_active;
    logic [POS_W-1:0] r_pos;
    t_enc             r_bytes;
    logic             r_out_valid;
    logic [7:0]       r_byte;
    logic             r_last;

    logic             n_active;
    logic [POS_W-1:0] n_pos;
    t_enc             n_bytes;
    logic             n_out_valid;
    logic [7:0]       n_byte;
    logic             n_last;

    logic             advance;
    logic             last_pos;
    logic             load;

    always_comb begin
        n_active    = r_active;
        n_pos       = r_pos;
        n_bytes     = r_bytes;
        n_out_valid = r_out_valid;
        n_byte      = r_byte;
        n_last      = r_last;

        advance  = !r_out_valid || !i_out_stall;
        last_pos = (r_pos == POS_W'(FRAME_LEN - 1));
        load     = !i_q_status.empty && (!r_active || (advance && last_pos));

        if (advance) begin
            n_out_valid = r_active;
            if (r_active) begin
                n_last = last_pos;
                n_pos  = r_pos + 1'b1;
                priority if (r_pos < POS_W'(PREAMBLE_LEN)) begin
                    n_byte = K_BYTE;
                end else if (r_pos < POS_W'(PAYLOAD_END)) begin
                    // Rotate so that the six bytes come round three times.
                    n_byte  = r_bytes[0];
                    n_bytes = {r_bytes[0], r_bytes[5:1]};
                end else begin
                    n_byte = NL_BYTE;
                end
                if (last_pos) begin
                    n_active = 1'b0;
                end
            end
        end

        if (load) begin
            n_bytes  = i_q_data;
            n_pos    = '0;
            n_active = 1'b1;
        end
    end

    assign o_pop        = load;
    assign o_out_valid  = r_out_valid;
    assign o_frame_byte = r_byte;
    assign o_frame_last = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
        r_byte  <= n_byte;
        r_last  <= n_last;
    end

endmodule

[sv/velocity_command_frame_encoder.sv]
// ----------------------------------------------------------------------------
// Velocity command frame encoder
// Turns x, y and rotation speed commands into 24-byte serial command frames.
// ----------------------------------------------------------------------------
// Usage. A command (three signed 16-bit speeds) is transferred on the input
// channel when i_in_valid is high and o_in_stall is low. Each command yields a
// frame of 24 byte transfers on the output channel: three 'k' bytes, the six
// encoded speed bytes sent three times over, and three newline bytes, the last
// of which carries o_frame_last. A byte is transferred when o_out_valid is
// high and i_out_stall is low.
// A command passes through the front end's command register and the queue
// before the back end registers the first byte of its frame. Bytes leave at
// one per cycle while i_out_stall is low, set by the single output byte lane.
// Frames follow each other with no gap while commands are queued. The front
// end encodes one command and a short queue holds further encoded commands,
// so up to Q_DEPTH + 1 commands are taken ahead of the serialiser.
// The limit registers are written over the configuration channel, which is
// always ready; writes to an index beyond the three limits are ignored.
// Reset (synchronous, active low) restores every limit to 1500 and empties
// the pipeline. When the receiver stalls, the current byte is held and the
// serialiser waits; o_in_stall rises once the queue and front end are full.
// ----------------------------------------------------------------------------
module velocity_command_frame_encoder
    import vcfe_pkg::*;
#(
    parameter int Q_DEPTH = Q_DEPTH_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LIMIT_W-1:0]   i_cfg_data,
    // Command input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic signed [15:0]   i_speed_x,
    input  logic signed [15:0]   i_speed_y,
    input  logic signed [15:0]   i_speed_rot,
    // Frame byte output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_frame_byte,
    output logic                 o_frame_last
);

    t_q_status q_status;
    t_enc      enc;
    t_enc      q_data;
    logic      push;
    logic      pop;

    // Limits may be written at any time the block is idle, so no back-pressure.
    assign o_cfg_ready = 1'b1;

    // Front end: limit registers, command register and the encoding logic.
    vcfe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_speed_x   (i_speed_x),
        .i_speed_y   (i_speed_y),
        .i_speed_rot (i_speed_rot),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_enc       (enc)
    );

    // Queue of encoded commands, letting front and back stall independently.
    vcfe_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (enc),
        .i_pop    (pop),
        .o_data   (q_data),
        .o_status (q_status)
    );

    // Back end: frame serialiser with a registered output byte.
    vcfe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_status   (q_status),
        .i_q_data     (q_data),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_frame_byte (o_frame_byte),
        .o_frame_last (o_frame_last)
    );

endmodule

[sv/vcfe_checker.sv]
// ----------------------------------------------------------------------------
// Velocity command frame encoder checker
// Port-level assertions on the output channel, bound to the top level.
// ----------------------------------------------------------------------------
module vcfe_checker
    import vcfe_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_frame_byte,
    input logic       o_frame_last
);

    // A stalled byte transfer keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_frame_byte) && $stable(o_frame_last)))
        else $error("stalled frame byte changed");

    // The final byte of a frame is always a newline.
    a_last_nl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_last) |-> (o_frame_byte == NL_BYTE))
        else $error("frame_last on a byte other than newline");

    // Frames never carry zero bytes or the reserved command letters.
    a_no_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_frame_byte != 8'h00) && (o_frame_byte != LC_R) &&
                         (o_frame_byte != UC_R) && (o_frame_byte != LC_W) &&
                         (o_frame_byte != UC_W)))
        else $error("reserved byte value in frame");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind velocity_command_frame_encoder vcfe_checker u_checker (.*);
